@@ src/clr_pkg.sv @@
// ----------------------------------------------------------------------------
// Clipped line rasterizer package
// Shared widths, codes and the structs passed between the line stepper and
// the top level.
// ----------------------------------------------------------------------------
package clr_pkg;

    localparam int COORD_W     = 14;
    localparam int ERR_W       = 16;
    localparam int COLOR_W     = 8;
    localparam int ADDR_W      = 16;
    localparam int ORIGIN_W    = 8;
    localparam int EXTENT_W    = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 24;

    // Operation codes carried in the input tuser bit.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Per-axis move codes, two's complement.
    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_POS  = 2'b01;
    localparam logic [1:0] STEP_NEG  = 2'b11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_ORIGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_ORIGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT   = 2'd3;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [COLOR_W-1:0] pixel_color;
    } t_line_req;

    // Pixel produced by the stepper; no_line marks a step with no line active.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
        logic               no_line;
    } t_pixel;

endpackage

@@ src/clr_stepper.sv @@
// ----------------------------------------------------------------------------
// Line stepper
// Holds the Bresenham state and advances it by one pixel per transaction.
// ----------------------------------------------------------------------------
module clr_stepper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  clr_pkg::t_line_req i_req,
    output clr_pkg::t_pixel    o_pixel
);

    localparam int CW = clr_pkg::COORD_W;
    localparam int EW = clr_pkg::ERR_W;

    logic [CW-1:0] r_cur_x, n_cur_x;
    logic [CW-1:0] r_cur_y, n_cur_y;
    logic [EW-1:0] r_err, n_err;
    logic [EW-1:0] r_diag_inc, n_diag_inc;
    logic [EW-1:0] r_str_inc, n_str_inc;
    logic [CW-1:0] r_remaining, n_remaining;
    logic [1:0]    r_diag_xs, n_diag_xs;
    logic [1:0]    r_diag_ys, n_diag_ys;
    logic [1:0]    r_str_xs, n_str_xs;
    logic [1:0]    r_str_ys, n_str_ys;
    logic [clr_pkg::COLOR_W-1:0] r_color, n_color;
    logic          r_active, n_active;
    logic          r_last, n_last;
    logic          r_no_line, n_no_line;

    logic [CW:0]   w_dx, w_dy, w_dx_neg, w_dy_neg;
    logic [CW-1:0] w_adx, w_ady, w_major, w_minor;
    logic          w_y_major;
    logic [1:0]    w_mx, w_my;

    always_comb begin
        w_dx     = {i_req.x_end[CW-1], i_req.x_end} - {i_req.x_start[CW-1], i_req.x_start};
        w_dy     = {i_req.y_end[CW-1], i_req.y_end} - {i_req.y_start[CW-1], i_req.y_start};
        w_dx_neg = (CW+1)'(0) - w_dx;
        w_dy_neg = (CW+1)'(0) - w_dy;
        w_adx    = w_dx[CW] ? w_dx_neg[CW-1:0] : w_dx[CW-1:0];
        w_ady    = w_dy[CW] ? w_dy_neg[CW-1:0] : w_dy[CW-1:0];
        // A tie in the deltas counts as x-major.
        w_y_major = w_adx < w_ady;
        w_major   = w_y_major ? w_ady : w_adx;
        w_minor   = w_y_major ? w_adx : w_ady;

        // Diagonal move when the error term is not negative.
        w_mx = r_err[EW-1] ? r_str_xs : r_diag_xs;
        w_my = r_err[EW-1] ? r_str_ys : r_diag_ys;

        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_err       = r_err;
        n_diag_inc  = r_diag_inc;
        n_str_inc   = r_str_inc;
        n_remaining = r_remaining;
        n_diag_xs   = r_diag_xs;
        n_diag_ys   = r_diag_ys;
        n_str_xs    = r_str_xs;
        n_str_ys    = r_str_ys;
        n_color     = r_color;
        n_active    = r_active;
        n_last      = r_last;
        n_no_line   = r_no_line;

        if (i_accept) begin
            if (i_req.operation == clr_pkg::OP_START) begin
                n_diag_xs   = w_dx[CW] ? clr_pkg::STEP_NEG : clr_pkg::STEP_POS;
                n_diag_ys   = w_dy[CW] ? clr_pkg::STEP_NEG : clr_pkg::STEP_POS;
                n_str_xs    = w_y_major ? clr_pkg::STEP_NONE : n_diag_xs;
                n_str_ys    = w_y_major ? n_diag_ys : clr_pkg::STEP_NONE;
                n_diag_inc  = {1'b0, w_minor, 1'b0} - {1'b0, w_major, 1'b0};
                n_str_inc   = {1'b0, w_minor, 1'b0};
                n_err       = {1'b0, w_minor, 1'b0} - {2'b00, w_major};
                n_cur_x     = i_req.x_start;
                n_cur_y     = i_req.y_start;
                n_color     = i_req.pixel_color;
                n_remaining = w_major;
                n_active    = w_major != '0;
                n_last      = w_major == '0;
                n_no_line   = 1'b0;
            end else if (r_active) begin
                n_cur_x     = r_cur_x + {{(CW-2){w_mx[1]}}, w_mx};
                n_cur_y     = r_cur_y + {{(CW-2){w_my[1]}}, w_my};
                n_err       = r_err + (r_err[EW-1] ? r_str_inc : r_diag_inc);
                n_remaining = r_remaining - CW'(1);
                n_active    = r_remaining != CW'(1);
                n_last      = r_remaining == CW'(1);
                n_no_line   = 1'b0;
            end else begin
                n_last    = 1'b1;
                n_no_line = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_err       <= n_err;
        r_diag_inc  <= n_diag_inc;
        r_str_inc   <= n_str_inc;
        r_remaining <= n_remaining;
        r_diag_xs   <= n_diag_xs;
        r_diag_ys   <= n_diag_ys;
        r_str_xs    <= n_str_xs;
        r_str_ys    <= n_str_ys;
        r_color     <= n_color;
        r_last      <= n_last;
        r_no_line   <= n_no_line;
    end

    assign o_pixel.x       = r_cur_x;
    assign o_pixel.y       = r_cur_y;
    assign o_pixel.color   = r_color;
    assign o_pixel.last    = r_last;
    assign o_pixel.no_line = r_no_line;

endmodule

@@ src/clipped_line_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// Clipped line rasterizer
// Bresenham line engine that turns start and step transactions into clipped
// frame-buffer pixel writes.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the output is not stalled
// and returns exactly one pixel write for each. The stepper registers its
// updated state, and the clip test and the row-pitch multiply then work
// on that registered pixel and are captured in the output
// register. A start transaction loads both endpoints and the color and emits
// the first pixel; each step transaction emits the next one, with tlast on the
// final pixel. A step with no line in progress returns a zero write with tlast
// set. Clipped pixels carry write enable low. Configuration may be written only
// while no transaction is in flight.
module clipped_line_rasterizer_top #(
    parameter int ROW_PITCH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: x_start[13:0], y_start[27:14], x_end[41:28], y_end[55:42],
    //        pixel_color[63:56]
    input  logic [clr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: operation
    input  logic                              s_axis_tuser,
    // Output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: write_address[15:0], write_color[23:16]
    output logic [clr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser: write_enable
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [clr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [clr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW = clr_pkg::COORD_W;
    localparam int AW = clr_pkg::ADDR_W;
    localparam logic [AW-1:0] PITCH = AW'(ROW_PITCH);

    logic [clr_pkg::ORIGIN_W-1:0] r_clip_x, r_clip_y;
    logic [clr_pkg::EXTENT_W-1:0] r_clip_w, r_clip_h;

    logic               w_accept;
    logic               w_advance;
    logic               r_s1_valid;
    clr_pkg::t_line_req w_req;
    clr_pkg::t_pixel    w_pix;

    logic [AW-1:0]      w_row;
    logic [2*AW-1:0]    w_prod;
    logic [AW-1:0]      w_addr;
    logic               w_visible;

    logic                         r_out_valid;
    logic [AW-1:0]                r_out_addr;
    logic [clr_pkg::COLOR_W-1:0]  r_out_color;
    logic                         r_out_we;
    logic                         r_out_last;

    assign w_req.operation   = s_axis_tuser;
    assign w_req.x_start     = s_axis_tdata[13:0];
    assign w_req.y_start     = s_axis_tdata[27:14];
    assign w_req.x_end       = s_axis_tdata[41:28];
    assign w_req.y_end       = s_axis_tdata[55:42];
    assign w_req.pixel_color = s_axis_tdata[63:56];

    // The stepper state holds while its pixel waits, so input stalls only when
    // both the pixel stage and the output register are full and blocked.
    assign w_advance     = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    clr_stepper u_stepper (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (w_req),
        .o_pixel  (w_pix)
    );

    // Address is formed modulo 2^16, so negative coordinates wrap naturally.
    always_comb begin
        w_row     = {{(AW-CW){w_pix.y[CW-1]}}, w_pix.y} + {{(AW-clr_pkg::ORIGIN_W){1'b0}}, r_clip_y};
        w_prod    = w_row * PITCH;
        w_addr    = w_prod[AW-1:0] + {{(AW-CW){w_pix.x[CW-1]}}, w_pix.x}
                    + {{(AW-clr_pkg::ORIGIN_W){1'b0}}, r_clip_x};
        w_visible = !w_pix.x[CW-1] && !w_pix.y[CW-1]
                    && (w_pix.x < {{(CW-clr_pkg::EXTENT_W){1'b0}}, r_clip_w})
                    && (w_pix.y < {{(CW-clr_pkg::EXTENT_W){1'b0}}, r_clip_h});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            if (w_pix.no_line) begin
                r_out_addr  <= '0;
                r_out_color <= '0;
                r_out_we    <= 1'b0;
            end else begin
                r_out_addr  <= w_addr;
                r_out_color <= w_pix.color;
                r_out_we    <= w_visible;
            end
            r_out_last <= w_pix.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_x <= '0;
            r_clip_y <= '0;
            r_clip_w <= 9'd256;
            r_clip_h <= 9'd224;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clr_pkg::REG_CLIP_X_ORIGIN: r_clip_x <= i_cfg_data[clr_pkg::ORIGIN_W-1:0];
                clr_pkg::REG_CLIP_Y_ORIGIN: r_clip_y <= i_cfg_data[clr_pkg::ORIGIN_W-1:0];
                clr_pkg::REG_CLIP_WIDTH:    r_clip_w <= i_cfg_data;
                clr_pkg::REG_CLIP_HEIGHT:   r_clip_h <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_color, r_out_addr};
    assign m_axis_tuser  = r_out_we;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ src/clr_checker.sv @@
// ----------------------------------------------------------------------------
// Clipped line rasterizer port checker
// Watches the stream ports for throughput and ordering slips.
// ----------------------------------------------------------------------------
module clr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [clr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);

    // A held result keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // Input backpressure comes only from a stalled output.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output is free");

    // A result appearing on an empty output came from a transaction accepted
    // into the stepper with no stall in between.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without matching transaction");

endmodule

bind clipped_line_rasterizer_top clr_checker u_clr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Clipped line rasterizer testbench
// Streams start and step transactions with random gaps and output stalls.
// A bit-exact line stepper predicts every pixel write, and each received
// write is compared field by field with the oldest prediction. The clip
// registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int ROW_PITCH = 256;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 225;

    typedef struct packed {
        logic [clr_pkg::ADDR_W-1:0]  addr;
        logic [clr_pkg::COLOR_W-1:0] color;
        logic                        wen;
        logic                        last;
    } t_pixel_write;

    typedef struct packed {
        logic                           op;
        logic [clr_pkg::IN_TDATA_W-1:0] data;
    } t_line_cmd;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [clr_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic                              s_axis_tuser = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [clr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                              m_axis_tuser;
    logic                              m_axis_tlast;
    logic                              i_cfg_we = 1'b0;
    logic [clr_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [clr_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;

    clipped_line_rasterizer_top #(
        .ROW_PITCH(ROW_PITCH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_line_cmd    line_cmds[$];
    t_pixel_write pending_writes[$];
    int           error_count = 0;

    // Predicted line stepper state and clip window.
    logic [clr_pkg::ORIGIN_W-1:0]       org_x, org_y;
    logic [clr_pkg::EXTENT_W-1:0]       clip_w, clip_h;
    logic signed [clr_pkg::COORD_W-1:0] cur_x, cur_y;
    logic signed [clr_pkg::ERR_W-1:0]   err, inc_diag, inc_straight;
    logic [clr_pkg::COORD_W-1:0]        steps_left;
    logic signed [1:0]                  diag_x_step, diag_y_step, str_x_step, str_y_step;
    logic [clr_pkg::COLOR_W-1:0]        line_color;
    logic                               line_active;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        error_count++;
    endtask

    function automatic t_pixel_write pixel_at(input logic last_flag);
        t_pixel_write pw;
        int cx, cy, addr;
        cx = int'(cur_x);
        cy = int'(cur_y);
        addr = (cy + int'(org_y)) * ROW_PITCH + cx + int'(org_x);
        pw.addr  = 16'(addr);
        pw.color = line_color;
        pw.wen   = (cx >= 0 && cx < int'(clip_w) && cy >= 0 && cy < int'(clip_h));
        pw.last  = last_flag;
        return pw;
    endfunction

    function automatic t_pixel_write rasterize_item(input logic op,
                                                    input logic [clr_pkg::IN_TDATA_W-1:0] data);
        int xs, ys, xe, ye, dx, dy, minor, major;
        logic signed [1:0] sx, sy;
        if (op == clr_pkg::OP_START) begin
            xs = int'($signed(data[13:0]));
            ys = int'($signed(data[27:14]));
            xe = int'($signed(data[41:28]));
            ye = int'($signed(data[55:42]));
            sx = (xe < xs) ? clr_pkg::STEP_NEG : clr_pkg::STEP_POS;
            sy = (ye < ys) ? clr_pkg::STEP_NEG : clr_pkg::STEP_POS;
            dx = (xe < xs) ? xs - xe : xe - xs;
            dy = (ye < ys) ? ys - ye : ye - ys;
            diag_x_step = sx;
            diag_y_step = sy;
            // A tie between the deltas counts as x-major.
            if (dx < dy) begin
                str_x_step = clr_pkg::STEP_NONE;
                str_y_step = sy;
                minor = dx;
                major = dy;
            end else begin
                str_x_step = sx;
                str_y_step = clr_pkg::STEP_NONE;
                minor = dy;
                major = dx;
            end
            inc_diag     = 16'(2 * minor - 2 * major);
            inc_straight = 16'(2 * minor);
            err          = 16'(2 * minor - major);
            cur_x        = 14'(xs);
            cur_y        = 14'(ys);
            line_color   = data[63:56];
            steps_left   = 14'(major);
            line_active  = (steps_left != 0);
            return pixel_at(!line_active);
        end
        if (!line_active) begin
            return '{addr: '0, color: '0, wen: 1'b0, last: 1'b1};
        end
        if (err >= 0) begin
            cur_x = 14'(int'(cur_x) + int'(diag_x_step));
            cur_y = 14'(int'(cur_y) + int'(diag_y_step));
            err   = err + inc_diag;
        end else begin
            cur_x = 14'(int'(cur_x) + int'(str_x_step));
            cur_y = 14'(int'(cur_y) + int'(str_y_step));
            err   = err + inc_straight;
        end
        steps_left  = steps_left - 1'b1;
        line_active = (steps_left != 0);
        return pixel_at(!line_active);
    endfunction

    // Usually no idle, sometimes a short gap, rarely a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Monitor: prediction on input transactions, checking on output ones.
    logic         in_accepted = 1'b0;
    t_pixel_write want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_accepted  <= 1'b0;
            org_x        = '0;
            org_y        = '0;
            clip_w       = 9'd256;
            clip_h       = 9'd224;
            cur_x        = '0;
            cur_y        = '0;
            err          = '0;
            inc_diag     = '0;
            inc_straight = '0;
            steps_left   = '0;
            diag_x_step  = clr_pkg::STEP_NONE;
            diag_y_step  = clr_pkg::STEP_NONE;
            str_x_step   = clr_pkg::STEP_NONE;
            str_y_step   = clr_pkg::STEP_NONE;
            line_color   = '0;
            line_active  = 1'b0;
        end else begin
            in_accepted <= s_axis_tvalid && s_axis_tready;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    clr_pkg::REG_CLIP_X_ORIGIN: org_x = i_cfg_data[clr_pkg::ORIGIN_W-1:0];
                    clr_pkg::REG_CLIP_Y_ORIGIN: org_y = i_cfg_data[clr_pkg::ORIGIN_W-1:0];
                    clr_pkg::REG_CLIP_WIDTH:    clip_w = i_cfg_data;
                    clr_pkg::REG_CLIP_HEIGHT:   clip_h = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_writes.push_back(rasterize_item(s_axis_tuser, s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_writes.size() == 0) begin
                    report_mismatch($sformatf("pixel write %h with none expected",
                                              m_axis_tdata));
                end else begin
                    want = pending_writes.pop_front();
                    if (m_axis_tdata[15:0] !== want.addr)
                        report_mismatch($sformatf("write_address got %h want %h",
                                                  m_axis_tdata[15:0], want.addr));
                    if (m_axis_tdata[23:16] !== want.color)
                        report_mismatch($sformatf("write_color got %h want %h",
                                                  m_axis_tdata[23:16], want.color));
                    if (m_axis_tuser !== want.wen)
                        report_mismatch($sformatf("write_enable got %b want %b",
                                                  m_axis_tuser, want.wen));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last got %b want %b",
                                                  m_axis_tlast, want.last));
                end
            end
        end
    end

    // Input driver: holds each transaction until accepted, then idles a while.
    t_line_cmd next_cmd;
    int        in_gap = 0;
    logic      in_burst = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !in_accepted)) begin
            if (in_gap > 0) begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (line_cmds.size() > 0) begin
                next_cmd = line_cmds.pop_front();
                s_axis_tuser  <= next_cmd.op;
                s_axis_tdata  <= next_cmd.data;
                s_axis_tvalid <= 1'b1;
                in_gap = in_burst ? 0 : idle_length();
                if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure.
    int   out_stall = 0;
    logic out_burst = 1'b0;

    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!out_burst) out_stall = idle_length();
            if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
        end
    end

    task automatic queue_step();
        line_cmds.push_back('{op: clr_pkg::OP_STEP, data: {$urandom, $urandom}});
    endtask

    task automatic queue_line(input int xs, input int ys, input int xe, input int ye,
                              input int color, input int n_steps);
        line_cmds.push_back('{op: clr_pkg::OP_START,
                              data: {8'(color), 14'(ye), 14'(xe), 14'(ys), 14'(xs)}});
        repeat (n_steps) queue_step();
    endtask

    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return int'($urandom_range(0, 319)) - 32;
        if (r < 85) return int'($urandom_range(0, 99)) - 8192;
        if (r < 92) return 8191 - int'($urandom_range(0, 99));
        return int'($urandom_range(0, 16383)) - 8192;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < -8192) return -8192;
        if (v > 8191) return 8191;
        return v;
    endfunction

    // Mostly whole lines; some cut short by the next start, some run past
    // their end, plus stray steps.
    task automatic queue_random_phase(input int n_items);
        int queued, xs, ys, xe, ye, dx, dy, major, n_steps, r;
        queued = 0;
        while (queued < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                queue_step();
                queued++;
            end else begin
                xs = rand_coord();
                ys = rand_coord();
                if (r < 10) begin
                    xe = xs;
                    ye = ys;
                end else if (r < 85) begin
                    xe = clamp_coord(xs + int'($urandom_range(0, 80)) - 40);
                    ye = clamp_coord(ys + int'($urandom_range(0, 80)) - 40);
                end else begin
                    xe = rand_coord();
                    ye = rand_coord();
                end
                dx = (xe < xs) ? xs - xe : xe - xs;
                dy = (ye < ys) ? ys - ye : ye - ys;
                major = (dx < dy) ? dy : dx;
                if (major > 64) begin
                    n_steps = $urandom_range(0, 24);
                end else begin
                    r = $urandom_range(0, 9);
                    if (r < 8) n_steps = major;
                    else if (r == 8) n_steps = $urandom_range(0, major);
                    else n_steps = major + $urandom_range(1, 3);
                end
                queue_line(xs, ys, xe, ye, $urandom_range(0, 255), n_steps);
                queued += 1 + n_steps;
            end
        end
    endtask

    task automatic write_clip(input int ox, input int oy, input int w, input int h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= clr_pkg::REG_CLIP_X_ORIGIN;
        i_cfg_data  <= 9'(ox);
        @(negedge i_clk);
        i_cfg_index <= clr_pkg::REG_CLIP_Y_ORIGIN;
        i_cfg_data  <= 9'(oy);
        @(negedge i_clk);
        i_cfg_index <= clr_pkg::REG_CLIP_WIDTH;
        i_cfg_data  <= 9'(w);
        @(negedge i_clk);
        i_cfg_index <= clr_pkg::REG_CLIP_HEIGHT;
        i_cfg_data  <= 9'(h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (line_cmds.size() != 0 || s_axis_tvalid || pending_writes.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int set_ox[5] = '{0, 255, 17, 128, 255};
        int set_oy[5] = '{0, 255, 200, 64, 0};
        int set_w[5]  = '{256, 256, 0, 1, 256};
        int set_h[5]  = '{256, 256, 0, 1, 224};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset clip window.
        queue_step();                                    // no line active yet
        queue_line(0, 0, 0, 0, 0, 1);                    // single point, then stray step
        queue_line(0, 0, 3, 0, 255, 4);                  // horizontal, runs one past end
        queue_line(5, 5, 8, 8, 8'h5A, 3);                // equal deltas
        queue_line(10, 10, 8, 4, 8'h11, 6);              // y-major, both directions negative
        queue_line(-8192, -8192, 8191, 8191, 8'h80, 1);  // extreme corners
        queue_line(8191, -8192, -8192, 8191, 8'hFF, 2);  // restart mid-line, address wraps
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 5) begin
                write_clip(set_ox[p], set_oy[p], set_w[p], set_h[p]);
            end else begin
                write_clip($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 256), $urandom_range(0, 256));
            end
            queue_random_phase(PHASE_LEN);
            wait_drained();
        end

        if (pending_writes.size() != 0) begin
            report_mismatch($sformatf("%0d pixel writes never arrived",
                                      pending_writes.size()));
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
